// ===== design/gbe_pkg.sv =====
package gbe_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);
  localparam int CHAR_W       = 8;
  localparam int REQ_W        = 3;
  localparam int STATUS_W     = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BACKSPACE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MOVE      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REPLACE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MV_RD,
    S_MV_WR,
    S_RP_RD,
    S_RP_WR,
    S_TOP_L,
    S_TOP_R,
    S_TOP_W
  } gbe_state_t;

endpackage

// ===== design/gbe_req_if.sv =====
interface gbe_req_if import gbe_pkg::*; #(
  parameter int CNT_W = CNT_W_DEF
) ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_value;
  logic [CHAR_W-1:0] replace_with;
  logic [CNT_W-1:0]  position;

  modport source (output valid, output req_type, output char_value,
                  output replace_with, output position, input ready);
  modport sink   (input valid, input req_type, input char_value,
                  input replace_with, input position, output ready);
endinterface

// ===== design/gbe_res_if.sv =====
interface gbe_res_if import gbe_pkg::*; #(
  parameter int CNT_W = CNT_W_DEF
) ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    left_size;
  logic [CNT_W-1:0]    right_size;
  logic [CHAR_W-1:0]   left_top;
  logic [CHAR_W-1:0]   right_top;

  modport source (output valid, output status, output left_size, output right_size,
                  output left_top, output right_top, input ready);
  modport sink   (input valid, input status, input left_size, input right_size,
                  input left_top, input right_top, output ready);
endinterface

// ===== design/gap_buffer_editor.sv =====
// Line buffer with a cursor, held as two stacks in one character RAM: the text
// left of the cursor grows up from entry 0, the text right of it grows down
// from the last entry. Each item is one request (insert, delete, backspace,
// absolute move, replace all) and gives one result with status, both sizes
// and the characters on either side of the cursor. Items are handled one at a
// time through the single RAM (one write, one registered read per cycle):
// insert, delete, backspace, unused codes and out-of-range moves are handled
// in the execute state, then both tops are read; a move within range first
// reads and writes each character carried across the cursor; a replace reads
// every stored entry and conditionally writes it back. A new item may be
// accepted while the previous result still waits in the output register. No
// clearing pass after reset.
module gap_buffer_editor import gbe_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gbe_req_if.sink   in_ch,
  gbe_res_if.source out_ch
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  gbe_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    left_r, left_nxt;
  logic [CNT_W-1:0]    right_r, right_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [CHAR_W-1:0]   ch_r, ch_nxt;
  logic [CHAR_W-1:0]   with_r, with_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                dir_left_r, dir_left_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic [CHAR_W-1:0]   ltop_r, ltop_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [CNT_W-1:0]    out_lsize_r, out_lsize_nxt;
  logic [CNT_W-1:0]    out_rsize_r, out_rsize_nxt;
  logic [CHAR_W-1:0]   out_ltop_r, out_ltop_nxt;
  logic [CHAR_W-1:0]   out_rtop_r, out_rtop_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  scan_full;
  logic [ADDR_W-1:0] scan_addr;
  logic [CNT_W-1:0]  rtop_full;
  logic [CNT_W-1:0]  rpush_full;
  logic [CNT_W-1:0]  ltop_full;
  logic              in_acc;
  logic              slot_free;

  gbe_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign total      = left_r + right_r;
  assign rtop_full  = CAP_C - right_r;
  assign rpush_full = CAP_C - right_r - ONE_C;
  assign ltop_full  = left_r - ONE_C;
  // right-side entries sit past the gap
  assign scan_full  = (scan_r < left_r) ? scan_r : (scan_r + CAP_C - total);
  assign scan_addr  = scan_full[ADDR_W-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.left_size  = out_lsize_r;
  assign out_ch.right_size = out_rsize_r;
  assign out_ch.left_top   = out_ltop_r;
  assign out_ch.right_top  = out_rtop_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (req_r == REQ_MOVE && pos_r <= total) begin
          state_nxt = S_MV_RD;
        end else if (req_r == REQ_REPLACE && total != '0) begin
          state_nxt = S_RP_RD;
        end else begin
          state_nxt = S_TOP_L;
        end
      end
      S_MV_RD: begin
        if (left_r > pos_r || (left_r < pos_r && right_r != '0)) begin
          state_nxt = S_MV_WR;
        end else begin
          state_nxt = S_TOP_L;
        end
      end
      S_MV_WR: state_nxt = S_MV_RD;
      S_RP_RD: state_nxt = S_RP_WR;
      S_RP_WR: begin
        if (scan_r + ONE_C == total) begin
          state_nxt = S_TOP_L;
        end else begin
          state_nxt = S_RP_RD;
        end
      end
      S_TOP_L: state_nxt = S_TOP_R;
      S_TOP_R: state_nxt = S_TOP_W;
      S_TOP_W: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    left_nxt       = left_r;
    right_nxt      = right_r;
    req_nxt        = req_r;
    ch_nxt         = ch_r;
    with_nxt       = with_r;
    pos_nxt        = pos_r;
    status_nxt     = status_r;
    dir_left_nxt   = dir_left_r;
    scan_nxt       = scan_r;
    ltop_nxt       = ltop_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_lsize_nxt  = out_lsize_r;
    out_rsize_nxt  = out_rsize_r;
    out_ltop_nxt   = out_ltop_r;
    out_rtop_nxt   = out_rtop_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_ch.req_type;
          ch_nxt     = in_ch.char_value;
          with_nxt   = in_ch.replace_with;
          pos_nxt    = in_ch.position;
          status_nxt = ST_DONE;
          scan_nxt   = '0;
        end
      end
      S_EXEC: begin
        unique case (req_r)
          REQ_INSERT: begin
            if (total == CAP_C) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = left_r[ADDR_W-1:0];
              mem_wdata = ch_r;
              left_nxt  = left_r + ONE_C;
            end
          end
          REQ_DELETE: begin
            if (right_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              right_nxt = right_r - ONE_C;
            end
          end
          REQ_BACKSPACE: begin
            if (left_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              left_nxt = left_r - ONE_C;
            end
          end
          REQ_MOVE: begin
            if (pos_r > total) begin
              status_nxt = ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      S_MV_RD: begin
        if (left_r > pos_r) begin
          dir_left_nxt = 1'b1;
          mem_raddr    = ltop_full[ADDR_W-1:0];
        end else begin
          dir_left_nxt = 1'b0;
          mem_raddr    = rtop_full[ADDR_W-1:0];
        end
      end
      S_MV_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (dir_left_r) begin
          mem_waddr = rpush_full[ADDR_W-1:0];
          right_nxt = right_r + ONE_C;
          left_nxt  = left_r - ONE_C;
        end else begin
          mem_waddr = left_r[ADDR_W-1:0];
          left_nxt  = left_r + ONE_C;
          right_nxt = right_r - ONE_C;
        end
      end
      S_RP_RD: begin
        mem_raddr = scan_addr;
      end
      S_RP_WR: begin
        if (mem_rdata == ch_r) begin
          mem_we    = 1'b1;
          mem_waddr = scan_addr;
          mem_wdata = with_r;
        end
        scan_nxt = scan_r + ONE_C;
      end
      S_TOP_L: begin
        mem_raddr = ltop_full[ADDR_W-1:0];
      end
      S_TOP_R: begin
        ltop_nxt  = (left_r != '0) ? mem_rdata : '0;
        mem_raddr = rtop_full[ADDR_W-1:0];
      end
      S_TOP_W: begin
        // hold the read address so the right top stays on the read port
        mem_raddr = rtop_full[ADDR_W-1:0];
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_lsize_nxt  = left_r;
          out_rsize_nxt  = right_r;
          out_ltop_nxt   = ltop_r;
          out_rtop_nxt   = (right_r != '0) ? mem_rdata : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    ch_r         <= ch_nxt;
    with_r       <= with_nxt;
    pos_r        <= pos_nxt;
    status_r     <= status_nxt;
    dir_left_r   <= dir_left_nxt;
    scan_r       <= scan_nxt;
    ltop_r       <= ltop_nxt;
    out_status_r <= out_status_nxt;
    out_lsize_r  <= out_lsize_nxt;
    out_rsize_r  <= out_rsize_nxt;
    out_ltop_r   <= out_ltop_nxt;
    out_rtop_r   <= out_rtop_nxt;
  end

endmodule

// ===== design/gbe_ram.sv =====
module gbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/gap_buffer_editor_tb.sv =====
module gap_buffer_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbe_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int CNT_W          = CNT_W_DEF;
  localparam int TOTAL_ITEMS    = 550;
  localparam int QUIET_FROM     = 500;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RESULT = 60;
  localparam int DRAIN_CYCLES   = 600;

  localparam logic [REQ_W-1:0]  REQ_SPARE_5 = 3'd5;
  localparam logic [REQ_W-1:0]  REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0]  REQ_SPARE_7 = 3'd7;
  localparam logic [CHAR_W-1:0] CHAR_A      = 8'h61;
  localparam int                ALPHABET    = 8;

  typedef enum {MODE_MIX, MODE_GROW} mix_mode_t;

  typedef struct {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_value;
    logic [CHAR_W-1:0] replace_with;
    logic [CNT_W-1:0]  position;
  } edit_request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    left_size;
    logic [CNT_W-1:0]    right_size;
    logic [CHAR_W-1:0]   left_top;
    logic [CHAR_W-1:0]   right_top;
  } edit_result_t;

  class edit_scoreboard;
    bit [CHAR_W-1:0] text_mem [CAP];
    int unsigned     left_cnt;
    int unsigned     right_cnt;
    int unsigned     peak_fill;
    edit_result_t    pending_q [$];
    int              errors;
    int              req_seen [8];
    int              status_seen [4];

    function void note_request(edit_request_t rq);
      logic [STATUS_W-1:0] st;
      edit_result_t        res;
      bit [CHAR_W-1:0]     c;
      int unsigned         i;
      st = ST_DONE;
      case (rq.req_type)
        REQ_INSERT: begin
          if (left_cnt + right_cnt >= CAP) begin
            st = ST_FULL;
          end else begin
            text_mem[left_cnt] = rq.char_value;
            left_cnt++;
          end
        end
        REQ_DELETE: begin
          if (right_cnt == 0) st = ST_EMPTY;
          else right_cnt--;
        end
        REQ_BACKSPACE: begin
          if (left_cnt == 0) st = ST_EMPTY;
          else left_cnt--;
        end
        REQ_MOVE: begin
          if (rq.position > left_cnt + right_cnt) begin
            st = ST_RANGE;
          end else begin
            // carry characters across the cursor one at a time
            while (left_cnt > rq.position) begin
              c = text_mem[left_cnt - 1];
              right_cnt++;
              text_mem[CAP - right_cnt] = c;
              left_cnt--;
            end
            while (left_cnt < rq.position && right_cnt > 0) begin
              c = text_mem[CAP - right_cnt];
              right_cnt--;
              text_mem[left_cnt] = c;
              left_cnt++;
            end
          end
        end
        REQ_REPLACE: begin
          for (i = 0; i < left_cnt; i++)
            if (text_mem[i] == rq.char_value) text_mem[i] = rq.replace_with;
          for (i = CAP - right_cnt; i < CAP; i++)
            if (text_mem[i] == rq.char_value) text_mem[i] = rq.replace_with;
        end
        default: ;
      endcase
      res.status     = st;
      res.left_size  = CNT_W'(left_cnt);
      res.right_size = CNT_W'(right_cnt);
      res.left_top   = (left_cnt > 0) ? text_mem[left_cnt - 1] : '0;
      res.right_top  = (right_cnt > 0) ? text_mem[CAP - right_cnt] : '0;
      pending_q.push_back(res);
      req_seen[rq.req_type]++;
      status_seen[st]++;
      if (left_cnt + right_cnt > peak_fill) peak_fill = left_cnt + right_cnt;
    endfunction

    function void check_result(edit_result_t got);
      edit_result_t exp;
      if (pending_q.size() == 0) begin
        $error("item on result channel with no request pending (status %0d)", got.status);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.left_size !== exp.left_size) begin
        $error("left_size: expected %0d, got %0d", exp.left_size, got.left_size);
        errors++;
      end
      if (got.right_size !== exp.right_size) begin
        $error("right_size: expected %0d, got %0d", exp.right_size, got.right_size);
        errors++;
      end
      if (got.left_top !== exp.left_top) begin
        $error("left_top: expected %02h, got %02h", exp.left_top, got.left_top);
        errors++;
      end
      if (got.right_top !== exp.right_top) begin
        $error("right_top: expected %02h, got %02h", exp.right_top, got.right_top);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sent;
  bit   quiet;

  edit_scoreboard sb = new;

  gbe_req_if #(.CNT_W(CNT_W)) in_ch ();
  gbe_res_if #(.CNT_W(CNT_W)) out_ch ();

  gap_buffer_editor #(.CAPACITY(CAP)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 3) != 0) return CHAR_A + CHAR_W'($urandom_range(0, ALPHABET - 1));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] rt, input logic [CHAR_W-1:0] ch,
                          input logic [CHAR_W-1:0] rw, input logic [CNT_W-1:0] pos);
    edit_request_t rq;
    rq = '{rt, ch, rw, pos};
    // idle bursts only in every other block of 64 items
    if (!quiet && ((sent / 64) % 2 == 0) && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= rt;
    in_ch.char_value   <= ch;
    in_ch.replace_with <= rw;
    in_ch.position     <= pos;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(rq);
    sent++;
    quiet = (sent >= QUIET_FROM);
  endtask

  task automatic issue_random(input mix_mode_t mode);
    int unsigned       roll;
    int unsigned       total;
    logic [REQ_W-1:0]  rt;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] rw;
    logic [CNT_W-1:0]  pos;
    roll  = $urandom_range(0, 99);
    total = sb.left_cnt + sb.right_cnt;
    ch    = pick_char();
    rw    = ($urandom_range(0, 1) != 0) ? pick_char() : CHAR_W'($urandom_range(0, 255));
    pos   = CNT_W'($urandom_range(0, 511));
    if (mode == MODE_GROW) begin
      rt = (roll < 88) ? REQ_INSERT :
           (roll < 96) ? REQ_MOVE :
           (roll < 98) ? REQ_REPLACE : REQ_BACKSPACE;
    end else begin
      rt = (roll < 40) ? REQ_INSERT :
           (roll < 52) ? REQ_DELETE :
           (roll < 64) ? REQ_BACKSPACE :
           (roll < 82) ? REQ_MOVE :
           (roll < 94) ? REQ_REPLACE :
           REQ_W'(REQ_SPARE_5 + $urandom_range(0, 2));
    end
    if (rt == REQ_MOVE) begin
      if ($urandom_range(0, 6) != 0) pos = CNT_W'($urandom_range(0, total));
      else pos = CNT_W'($urandom_range(total + 1, 511));
    end
    send_req(rt, ch, rw, pos);
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned  stall_cnt;
    int unsigned  hold_cnt;
    int unsigned  checked;
    bit           held;
    bit           next_ready;
    edit_result_t got;
    stall_cnt = 0;
    hold_cnt  = 0;
    checked   = 0;
    held      = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.left_size, out_ch.right_size,
                out_ch.left_top, out_ch.right_top};
        sb.check_result(got);
        checked++;
      end
      if (!held && checked == HOLD_AT_RESULT) begin
        held     = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        next_ready = 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        next_ready = 1'b0;
      end else if (!quiet && ((checked / 50) % 2 == 1) && $urandom_range(0, 5) == 0) begin
        stall_cnt  = $urandom_range(1, 19) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ch.ready <= next_ready;
      @(posedge clk);
    end
  end

  initial begin
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("no item moved for %0d cycles, giving up", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sent  = 0;
    quiet = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_INSERT;
    in_ch.char_value   <= '0;
    in_ch.replace_with <= '0;
    in_ch.position     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty line corner cases
    send_req(REQ_DELETE,    8'h00, 8'h00, 9'd0);
    send_req(REQ_BACKSPACE, 8'hFF, 8'hFF, 9'd0);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd1);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd0);
    send_req(REQ_REPLACE,   8'h00, 8'hFF, 9'd0);
    send_req(REQ_INSERT,    8'h00, 8'h00, 9'd0);
    send_req(REQ_INSERT,    8'hFF, 8'h00, 9'd511);
    send_req(REQ_INSERT,    CHAR_A, 8'h00, 9'd0);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd0);
    send_req(REQ_INSERT,    CHAR_A + 8'd1, 8'h00, 9'd0);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd511);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd256);
    send_req(REQ_REPLACE,   CHAR_A, 8'hFF, 9'd0);
    send_req(REQ_REPLACE,   8'hFF, 8'h00, 9'd0);
    send_req(REQ_DELETE,    8'h00, 8'h00, 9'd0);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd3);
    send_req(REQ_DELETE,    8'h00, 8'h00, 9'd0);
    send_req(REQ_BACKSPACE, 8'h00, 8'h00, 9'd0);
    send_req(REQ_SPARE_5,   8'h00, 8'h00, 9'd0);
    send_req(REQ_SPARE_6,   8'h55, 8'hAA, 9'd170);
    send_req(REQ_SPARE_7,   8'hFF, 8'hFF, 9'd511);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd1);
    send_req(REQ_REPLACE,   8'h00, 8'h00, 9'd0);

    repeat (60) issue_random(MODE_MIX);
    while (sb.left_cnt + sb.right_cnt < CAP && sent < 450) issue_random(MODE_GROW);

    // full store: rejected inserts, moves at both ends, refill
    send_req(REQ_INSERT,    pick_char(), 8'h00, 9'd0);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd256);
    send_req(REQ_INSERT,    pick_char(), 8'h00, 9'd0);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd257);
    send_req(REQ_MOVE,      8'h00, 8'h00, 9'd0);
    send_req(REQ_INSERT,    pick_char(), 8'h00, 9'd0);
    send_req(REQ_REPLACE,   pick_char(), pick_char(), 9'd0);
    send_req(REQ_DELETE,    8'h00, 8'h00, 9'd0);
    send_req(REQ_INSERT,    pick_char(), 8'h00, 9'd0);
    send_req(REQ_INSERT,    pick_char(), 8'h00, 9'd0);

    while (sent < TOTAL_ITEMS) issue_random(MODE_MIX);
    in_ch.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d insert, %0d delete, %0d backspace, %0d move, %0d replace, %0d unused",
             sent, sb.req_seen[REQ_INSERT], sb.req_seen[REQ_DELETE],
             sb.req_seen[REQ_BACKSPACE], sb.req_seen[REQ_MOVE], sb.req_seen[REQ_REPLACE],
             sb.req_seen[REQ_SPARE_5] + sb.req_seen[REQ_SPARE_6] + sb.req_seen[REQ_SPARE_7]);
    $display("outcomes: %0d done, %0d empty side, %0d out of range, %0d full; peak fill %0d of %0d",
             sb.status_seen[ST_DONE], sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE],
             sb.status_seen[ST_FULL], sb.peak_fill, CAP);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/gbe_pkg.sv
design/gbe_req_if.sv
design/gbe_res_if.sv
design/gbe_ram.sv
design/gap_buffer_editor.sv
verif/gap_buffer_editor_tb.sv
